@@ sv/hbws_pkg.sv @@
// Shared types and constants for the heartbeat watchdog supervisor.
`timescale 1ns / 1ps

package hbws_pkg;

  localparam int TIME_W  = 32;
  localparam int COUNT_W = 8;
  localparam int DELAY_W = 16;
  localparam int LIMIT_W = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;

  localparam logic [DELAY_W-1:0] ACTIVATE_PULSE_RST = DELAY_W'(500);
  localparam logic [DELAY_W-1:0] HB_INTERVAL_RST    = DELAY_W'(1000);
  localparam logic [DELAY_W-1:0] BB_TIMEOUT_RST     = DELAY_W'(200);
  localparam logic [LIMIT_W-1:0] FAULT_LIMIT_RST    = LIMIT_W'(4);
  localparam logic [COUNT_W-1:0] COUNT_MAX          = {COUNT_W{1'b1}};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVATE_PULSE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HB_INTERVAL    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BB_TIMEOUT     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAULT_LIMIT    = 2'd3;

  typedef enum logic [3:0] {
    PH_WAIT     = 4'd0,
    PH_PULSE_ON = 4'd1,
    PH_PULSE_HI = 4'd2,
    PH_CYCLE    = 4'd3,
    PH_HI_SET   = 4'd4,
    PH_BB_LOW   = 4'd5,
    PH_HOLD_HI  = 4'd6,
    PH_LO_SET   = 4'd7,
    PH_BB_HIGH  = 4'd8,
    PH_HOLD_LO  = 4'd9,
    PH_CHECK    = 4'd10
  } phase_t;

  typedef struct packed {
    logic [DELAY_W-1:0] activate_pulse_ms;
    logic [DELAY_W-1:0] heartbeat_interval_ms;
    logic [DELAY_W-1:0] beatback_timeout_ms;
    logic [LIMIT_W-1:0] fault_limit;
  } cfg_t;

  typedef struct packed {
    phase_t             phase;
    logic [TIME_W-1:0]  interval_deadline;
    logic [TIME_W-1:0]  beatback_deadline;
    logic [COUNT_W-1:0] faults;
    logic [COUNT_W-1:0] restarts;
    logic               armed;
    logic               heartbeat;
  } state_t;

  typedef struct packed {
    logic               sensor_error;
    logic               radio_error;
    logic               beatback_level;
    logic               watchdog_present;
    logic [TIME_W-1:0]  now_ms;
  } tick_t;

  typedef struct packed {
    logic [COUNT_W-1:0] restart_count;
    logic               restart_event;
    logic [COUNT_W-1:0] fault_count;
    logic               kick_internal_watchdog;
    logic               arm_internal_watchdog;
    logic               heartbeat_level;
  } result_t;

endpackage

@@ sv/hbws_step.sv @@
// Next-state and result logic for one supervisor tick.
`timescale 1ns / 1ps

module hbws_step (
  input  hbws_pkg::state_t  state_i,
  input  hbws_pkg::cfg_t    cfg_i,
  input  hbws_pkg::tick_t   tick_i,
  output hbws_pkg::state_t  state_o,
  output hbws_pkg::result_t result_o
);

  logic [hbws_pkg::TIME_W-1:0]  now;
  logic [hbws_pkg::TIME_W-1:0]  pulse_dl;
  logic [hbws_pkg::TIME_W-1:0]  interval_dl;
  logic [hbws_pkg::TIME_W-1:0]  beatback_dl;
  logic                         interval_passed;
  logic                         beatback_passed;
  logic [hbws_pkg::COUNT_W-1:0] faults_inc;
  logic [hbws_pkg::COUNT_W-1:0] restarts_inc;
  logic                         over_limit;
  hbws_pkg::phase_t             phase_nxt;

  assign now = tick_i.now_ms;
  // Deadlines wrap at the time width
  assign pulse_dl    = now + hbws_pkg::TIME_W'(cfg_i.activate_pulse_ms);
  assign interval_dl = now + hbws_pkg::TIME_W'(cfg_i.heartbeat_interval_ms);
  assign beatback_dl = now + hbws_pkg::TIME_W'(cfg_i.beatback_timeout_ms);
  assign interval_passed = now > state_i.interval_deadline;
  assign beatback_passed = now > state_i.beatback_deadline;
  assign faults_inc = (state_i.faults == hbws_pkg::COUNT_MAX) ?
                      state_i.faults : state_i.faults + 1'b1;
  assign restarts_inc = (state_i.restarts == hbws_pkg::COUNT_MAX) ?
                        state_i.restarts : state_i.restarts + 1'b1;
  assign over_limit = state_i.faults > hbws_pkg::COUNT_W'(cfg_i.fault_limit);

  // Phase sequencing
  always_comb begin
    phase_nxt = state_i.phase;
    case (state_i.phase)
      hbws_pkg::PH_PULSE_ON: phase_nxt = hbws_pkg::PH_PULSE_HI;
      hbws_pkg::PH_PULSE_HI: if (interval_passed) phase_nxt = hbws_pkg::PH_CYCLE;
      hbws_pkg::PH_CYCLE:    phase_nxt = hbws_pkg::PH_HI_SET;
      hbws_pkg::PH_HI_SET:   phase_nxt = hbws_pkg::PH_BB_LOW;
      hbws_pkg::PH_BB_LOW: begin
        if (!tick_i.beatback_level || beatback_passed) phase_nxt = hbws_pkg::PH_HOLD_HI;
      end
      hbws_pkg::PH_HOLD_HI:  if (interval_passed) phase_nxt = hbws_pkg::PH_LO_SET;
      hbws_pkg::PH_LO_SET:   phase_nxt = hbws_pkg::PH_BB_HIGH;
      hbws_pkg::PH_BB_HIGH: begin
        if (tick_i.beatback_level || beatback_passed) phase_nxt = hbws_pkg::PH_HOLD_LO;
      end
      hbws_pkg::PH_HOLD_LO:  if (interval_passed) phase_nxt = hbws_pkg::PH_CHECK;
      hbws_pkg::PH_CHECK:    phase_nxt = hbws_pkg::PH_CYCLE;
      default: begin
        phase_nxt = tick_i.watchdog_present ? hbws_pkg::PH_PULSE_ON : hbws_pkg::PH_WAIT;
      end
    endcase
  end

  // Datapath and result fields
  always_comb begin
    state_o       = state_i;
    state_o.phase = phase_nxt;
    result_o      = '0;
    case (state_i.phase)
      hbws_pkg::PH_PULSE_ON: begin
        state_o.heartbeat         = 1'b1;
        state_o.interval_deadline = pulse_dl;
      end
      hbws_pkg::PH_PULSE_HI: begin
        if (interval_passed) begin
          state_o.heartbeat         = 1'b0;
          state_o.interval_deadline = pulse_dl;
        end
      end
      hbws_pkg::PH_HI_SET, hbws_pkg::PH_LO_SET: begin
        state_o.heartbeat         = (state_i.phase == hbws_pkg::PH_HI_SET);
        state_o.interval_deadline = interval_dl;
        state_o.beatback_deadline = beatback_dl;
      end
      hbws_pkg::PH_BB_LOW: begin
        if (tick_i.beatback_level && beatback_passed) state_o.faults = faults_inc;
      end
      hbws_pkg::PH_BB_HIGH: begin
        if (!tick_i.beatback_level && beatback_passed) state_o.faults = faults_inc;
      end
      hbws_pkg::PH_CHECK: begin
        if (over_limit) begin
          state_o.faults         = '0;
          state_o.restarts       = restarts_inc;
          result_o.restart_event = 1'b1;
        end
      end
      hbws_pkg::PH_CYCLE, hbws_pkg::PH_HOLD_HI, hbws_pkg::PH_HOLD_LO: ;
      default: begin
        if (tick_i.watchdog_present) begin
          state_o.faults                 = '0;
          state_o.armed                  = 1'b1;
          result_o.arm_internal_watchdog = 1'b1;
        end
      end
    endcase
    result_o.heartbeat_level        = state_o.heartbeat;
    result_o.kick_internal_watchdog = state_o.armed & ~tick_i.radio_error &
                                      ~tick_i.sensor_error;
    result_o.fault_count   = state_o.faults;
    result_o.restart_count = state_o.restarts;
  end

endmodule

@@ sv/heartbeat_watchdog_supervisor_unit.sv @@
// Top level of the heartbeat watchdog supervisor: ports, registers and handshake.
`timescale 1ns / 1ps

// One tick is taken per clock cycle while in_tready is high. A tick transfer on
// the input lands in an input register; when the result stage advances, the
// tick logic updates the supervisor state and loads the result register, and
// results follow at the full input rate while out_tready is high. When the
// result is not taken the result register holds; the input register still takes
// one more tick while it is empty, then in_tready stays low until the result
// moves. Configuration writes take effect on the next cycle and should be made
// only while no tick is in flight.
module heartbeat_watchdog_supervisor_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // now_ms[31:0], watchdog_present, beatback_level, radio_error, sensor_error, zero pad
  input  logic [hbws_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // heartbeat_level, arm_internal_watchdog, kick_internal_watchdog, fault_count[7:0],
  // restart_event, restart_count[7:0], zero pad
  output logic [hbws_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic [hbws_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hbws_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int TICK_W   = $bits(hbws_pkg::tick_t);
  localparam int RESULT_W = $bits(hbws_pkg::result_t);

  hbws_pkg::cfg_t    cfg_r;
  hbws_pkg::state_t  st_r;
  hbws_pkg::state_t  st_nxt;
  hbws_pkg::tick_t   tick_r;
  hbws_pkg::result_t res_r;
  hbws_pkg::result_t res_nxt;
  logic              in_valid_r;
  logic              out_valid_r;
  logic              advance;

  assign advance    = !out_valid_r || out_tready;
  assign in_tready  = !in_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(hbws_pkg::OUT_DATA_W - RESULT_W){1'b0}}, res_r};

  hbws_step u_step (
    .state_i  (st_r),
    .cfg_i    (cfg_r),
    .tick_i   (tick_r),
    .state_o  (st_nxt),
    .result_o (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.activate_pulse_ms     <= hbws_pkg::ACTIVATE_PULSE_RST;
      cfg_r.heartbeat_interval_ms <= hbws_pkg::HB_INTERVAL_RST;
      cfg_r.beatback_timeout_ms   <= hbws_pkg::BB_TIMEOUT_RST;
      cfg_r.fault_limit           <= hbws_pkg::FAULT_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hbws_pkg::CFG_ACTIVATE_PULSE: cfg_r.activate_pulse_ms     <= cfg_wdata;
        hbws_pkg::CFG_HB_INTERVAL:    cfg_r.heartbeat_interval_ms <= cfg_wdata;
        hbws_pkg::CFG_BB_TIMEOUT:     cfg_r.beatback_timeout_ms   <= cfg_wdata;
        hbws_pkg::CFG_FAULT_LIMIT:
          cfg_r.fault_limit <= cfg_wdata[hbws_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      tick_r <= hbws_pkg::tick_t'(in_tdata[TICK_W-1:0]);
    end
  end

  // Tick stage: advance state and load the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase             <= hbws_pkg::PH_WAIT;
      st_r.interval_deadline <= '0;
      st_r.beatback_deadline <= '0;
      st_r.faults            <= '0;
      st_r.restarts          <= '0;
      st_r.armed             <= 1'b0;
      st_r.heartbeat         <= 1'b0;
      out_valid_r            <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
      if (in_valid_r) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      res_r <= res_nxt;
    end
  end

  a_restart_clears_faults: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.restart_event |-> res_r.fault_count == '0)
    else $error("restart result carries a nonzero fault count");

  a_kick_needs_armed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.kick_internal_watchdog |-> st_r.armed)
    else $error("kick issued while internal watchdog not armed");

  a_restarts_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> st_r.restarts >= $past(st_r.restarts))
    else $error("restart count decreased");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_valid_r && out_valid_r)
    else $error("input stalled with a free stage");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the heartbeat watchdog supervisor: directed ticks, then random ticks.
`timescale 1ns / 1ps

module tb_top;

  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 80;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [hbws_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [hbws_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            cfg_we = 1'b0;
  logic [hbws_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [hbws_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Supervisor state as the testbench sees it
  hbws_pkg::phase_t             hb_phase = hbws_pkg::PH_WAIT;
  logic [hbws_pkg::TIME_W-1:0]  iv_deadline = '0;
  logic [hbws_pkg::TIME_W-1:0]  bb_deadline = '0;
  logic [hbws_pkg::COUNT_W-1:0] miss_count = '0;
  logic [hbws_pkg::COUNT_W-1:0] restart_total = '0;
  logic                         wd_armed = 1'b0;
  logic                         hb_level = 1'b0;

  logic [hbws_pkg::DELAY_W-1:0] cfg_pulse_ms = hbws_pkg::ACTIVATE_PULSE_RST;
  logic [hbws_pkg::DELAY_W-1:0] cfg_interval_ms = hbws_pkg::HB_INTERVAL_RST;
  logic [hbws_pkg::DELAY_W-1:0] cfg_timeout_ms = hbws_pkg::BB_TIMEOUT_RST;
  logic [hbws_pkg::LIMIT_W-1:0] cfg_fault_limit = hbws_pkg::FAULT_LIMIT_RST;

  hbws_pkg::result_t           expected_results[$];
  logic [hbws_pkg::TIME_W-1:0] clock_ms = '0;
  int                          fail_count = 0;
  int                          quiet_cycles = 0;
  int                          hold_left = 0;
  int                          stall_left = 0;
  bit                          hold_req = 1'b0;
  bit                          tx_quiet = 1'b0;
  bit                          rx_quiet = 1'b0;

  heartbeat_watchdog_supervisor_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic hbws_pkg::result_t predict_tick(hbws_pkg::tick_t t);
    hbws_pkg::result_t r;
    logic              arm_now;
    logic              restart_now;
    arm_now = 1'b0;
    restart_now = 1'b0;
    case (hb_phase)
      hbws_pkg::PH_PULSE_ON: begin
        hb_level = 1'b1;
        iv_deadline = t.now_ms + hbws_pkg::TIME_W'(cfg_pulse_ms);
        hb_phase = hbws_pkg::PH_PULSE_HI;
      end
      hbws_pkg::PH_PULSE_HI: begin
        if (t.now_ms > iv_deadline) begin
          hb_level = 1'b0;
          iv_deadline = t.now_ms + hbws_pkg::TIME_W'(cfg_pulse_ms);
          hb_phase = hbws_pkg::PH_CYCLE;
        end
      end
      hbws_pkg::PH_CYCLE: hb_phase = hbws_pkg::PH_HI_SET;
      hbws_pkg::PH_HI_SET: begin
        hb_level = 1'b1;
        iv_deadline = t.now_ms + hbws_pkg::TIME_W'(cfg_interval_ms);
        bb_deadline = t.now_ms + hbws_pkg::TIME_W'(cfg_timeout_ms);
        hb_phase = hbws_pkg::PH_BB_LOW;
      end
      hbws_pkg::PH_BB_LOW: begin
        if (!t.beatback_level) begin
          hb_phase = hbws_pkg::PH_HOLD_HI;
        end else if (t.now_ms > bb_deadline) begin
          if (miss_count != hbws_pkg::COUNT_MAX) miss_count = miss_count + 1'b1;
          hb_phase = hbws_pkg::PH_HOLD_HI;
        end
      end
      hbws_pkg::PH_HOLD_HI: if (t.now_ms > iv_deadline) hb_phase = hbws_pkg::PH_LO_SET;
      hbws_pkg::PH_LO_SET: begin
        hb_level = 1'b0;
        iv_deadline = t.now_ms + hbws_pkg::TIME_W'(cfg_interval_ms);
        bb_deadline = t.now_ms + hbws_pkg::TIME_W'(cfg_timeout_ms);
        hb_phase = hbws_pkg::PH_BB_HIGH;
      end
      hbws_pkg::PH_BB_HIGH: begin
        if (t.beatback_level) begin
          hb_phase = hbws_pkg::PH_HOLD_LO;
        end else if (t.now_ms > bb_deadline) begin
          if (miss_count != hbws_pkg::COUNT_MAX) miss_count = miss_count + 1'b1;
          hb_phase = hbws_pkg::PH_HOLD_LO;
        end
      end
      hbws_pkg::PH_HOLD_LO: if (t.now_ms > iv_deadline) hb_phase = hbws_pkg::PH_CHECK;
      hbws_pkg::PH_CHECK: begin
        if (miss_count > cfg_fault_limit) begin
          miss_count = '0;
          if (restart_total != hbws_pkg::COUNT_MAX) restart_total = restart_total + 1'b1;
          restart_now = 1'b1;
        end
        hb_phase = hbws_pkg::PH_CYCLE;
      end
      default: begin
        hb_phase = hbws_pkg::PH_WAIT;
        if (t.watchdog_present) begin
          miss_count = '0;
          wd_armed = 1'b1;
          arm_now = 1'b1;
          hb_phase = hbws_pkg::PH_PULSE_ON;
        end
      end
    endcase
    r.heartbeat_level = hb_level;
    r.arm_internal_watchdog = arm_now;
    r.kick_internal_watchdog = wd_armed && !t.radio_error && !t.sensor_error;
    r.fault_count = miss_count;
    r.restart_event = restart_now;
    r.restart_count = restart_total;
    return r;
  endfunction

  function automatic hbws_pkg::tick_t mk_tick(logic [hbws_pkg::TIME_W-1:0] now, logic present,
                                              logic bb, logic radio, logic sensor);
    hbws_pkg::tick_t t;
    t.now_ms = now;
    t.watchdog_present = present;
    t.beatback_level = bb;
    t.radio_error = radio;
    t.sensor_error = sensor;
    return t;
  endfunction

  // Advance, hold or jump the millisecond clock and build a tick whose beatback
  // follows, opposes or ignores the heartbeat in the given proportions.
  function automatic hbws_pkg::tick_t next_tick(int follow_pct, int miss_pct, int step_max,
                                                int jump_pct);
    int              r;
    hbws_pkg::tick_t t;
    r = $urandom_range(0, 99);
    if (r < jump_pct) clock_ms = $urandom;
    else if (r >= jump_pct + 8) clock_ms = clock_ms + $urandom_range(1, step_max);
    t.now_ms = clock_ms;
    t.watchdog_present = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < follow_pct) t.beatback_level = ~hb_level;
    else if (r < follow_pct + miss_pct) t.beatback_level = hb_level;
    else t.beatback_level = 1'($urandom_range(0, 1));
    t.radio_error = ($urandom_range(0, 99) < 15);
    t.sensor_error = ($urandom_range(0, 99) < 15);
    return t;
  endfunction

  task automatic send_tick(input hbws_pkg::tick_t t);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= hbws_pkg::IN_DATA_W'(t);
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(predict_tick(t));
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [hbws_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hbws_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      hbws_pkg::CFG_ACTIVATE_PULSE: cfg_pulse_ms = val;
      hbws_pkg::CFG_HB_INTERVAL:    cfg_interval_ms = val;
      hbws_pkg::CFG_BB_TIMEOUT:     cfg_timeout_ms = val;
      hbws_pkg::CFG_FAULT_LIMIT:    cfg_fault_limit = val[hbws_pkg::LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [hbws_pkg::DELAY_W-1:0] pulse,
                            input logic [hbws_pkg::DELAY_W-1:0] interval,
                            input logic [hbws_pkg::DELAY_W-1:0] timeout,
                            input logic [hbws_pkg::LIMIT_W-1:0] limit);
    write_reg(hbws_pkg::CFG_ACTIVATE_PULSE, pulse);
    write_reg(hbws_pkg::CFG_HB_INTERVAL, interval);
    write_reg(hbws_pkg::CFG_BB_TIMEOUT, timeout);
    write_reg(hbws_pkg::CFG_FAULT_LIMIT, hbws_pkg::CFG_DATA_W'(limit));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [hbws_pkg::DELAY_W-1:0] pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return '0;
    if (r < 40) return '1;
    if (r < 80) return hbws_pkg::DELAY_W'($urandom_range(1, 40));
    return hbws_pkg::DELAY_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [hbws_pkg::LIMIT_W-1:0] pick_limit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return '0;
    if (r < 35) return 8'd254;
    if (r < 45) return 8'd255;
    if (r < 85) return hbws_pkg::LIMIT_W'($urandom_range(1, 6));
    return hbws_pkg::LIMIT_W'($urandom_range(0, 255));
  endfunction

  // Idle ticks, arming, the activation pulse across the time wrap, then
  // clean cycles and missed beatbacks with zero delays.
  task automatic test_arm_and_wrap();
    int i;
    set_config('1, '0, '0, '0);
    send_tick(mk_tick(32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0));
    send_tick(mk_tick(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b1));
    send_tick(mk_tick(32'hFFFF_FFF0, 1'b1, 1'b0, 1'b1, 1'b0));
    send_tick(mk_tick(32'hFFFF_FFF8, 1'b0, 1'b1, 1'b0, 1'b1));
    // pulse deadline wrapped past zero, so it expires at once
    send_tick(mk_tick(32'hFFFF_FFF9, 1'b1, 1'b1, 1'b0, 1'b0));
    clock_ms = 32'd100;
    for (i = 0; i < 8; i++) begin
      if (i != 3) clock_ms = clock_ms + 1'b1;
      send_tick(mk_tick(clock_ms, 1'b0, ~hb_level, 1'b0, 1'b0));
    end
    for (i = 0; i < 10; i++) begin
      clock_ms = clock_ms + 1'b1;
      send_tick(mk_tick(clock_ms, 1'b1, hb_level, i[0], 1'b0));
    end
    drain_results();
  endtask

  // Stall the result side long enough for the block to back up its input,
  // then let the sender wait for every result before going on.
  task automatic test_backpressure();
    int i;
    set_config(16'd3, 16'd4, 16'd2, 8'd1);
    hold_req = 1'b1;
    tx_quiet = 1'b1;
    for (i = 0; i < 40; i++) send_tick(next_tick(80, 10, 3, 0));
    tx_quiet = 1'b0;
    drain_results();
    for (i = 0; i < 30; i++) send_tick(next_tick(80, 10, 3, 0));
    drain_results();
  endtask

  task automatic test_random_configs();
    int                           ph;
    int                           i;
    int                           follow;
    int                           step_max;
    logic [hbws_pkg::DELAY_W-1:0] interval;
    logic [hbws_pkg::DELAY_W-1:0] timeout;
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin interval = '0; timeout = '0; set_config('0, interval, timeout, '0); end
        1: begin interval = '1; timeout = '1; set_config('1, interval, timeout, 8'd255); end
        default: begin
          interval = pick_delay();
          timeout = pick_delay();
          set_config(pick_delay(), interval, timeout, pick_limit());
        end
      endcase
      follow = (ph % 3 == 0) ? 95 : (ph % 3 == 1) ? 75 : 40;
      step_max = ((interval > timeout) ? int'(interval) : int'(timeout)) / 6 + 3;
      tx_quiet = (ph == 2);
      rx_quiet = (ph == 2);
      for (i = 0; i < 50; i++) send_tick(next_tick(follow, (100 - follow) / 2, step_max, 3));
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
      drain_results();
    end
  endtask

  // A limit of 255 is never exceeded, so the miss count climbs to its ceiling.
  task automatic test_fault_saturation();
    int i;
    set_config('0, '0, '0, 8'd255);
    for (i = 0; i < 1150; i++) send_tick(next_tick(0, 100, 1, 0));
    drain_results();
  endtask

  // Limit zero: every cycle with a miss restarts.
  task automatic test_restart_saturation();
    int i;
    set_config('0, '0, '0, '0);
    for (i = 0; i < 150; i++) send_tick(next_tick(0, 100, 1, 0));
    drain_results();
  endtask

  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (stall_left == 0) stall_left = pick_gap(rx_quiet);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    hbws_pkg::result_t got;
    hbws_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = hbws_pkg::result_t'(out_tdata[$bits(hbws_pkg::result_t)-1:0]);
      if (expected_results.size() == 0) begin
        $error("result 0x%0h arrived with nothing expected", out_tdata);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.heartbeat_level !== want.heartbeat_level) begin
          $error("heartbeat_level: expected %0d, got %0d", want.heartbeat_level,
                 got.heartbeat_level);
          fail_count++;
        end
        if (got.arm_internal_watchdog !== want.arm_internal_watchdog) begin
          $error("arm_internal_watchdog: expected %0d, got %0d",
                 want.arm_internal_watchdog, got.arm_internal_watchdog);
          fail_count++;
        end
        if (got.kick_internal_watchdog !== want.kick_internal_watchdog) begin
          $error("kick_internal_watchdog: expected %0d, got %0d",
                 want.kick_internal_watchdog, got.kick_internal_watchdog);
          fail_count++;
        end
        if (got.fault_count !== want.fault_count) begin
          $error("fault_count: expected %0d, got %0d", want.fault_count, got.fault_count);
          fail_count++;
        end
        if (got.restart_event !== want.restart_event) begin
          $error("restart_event: expected %0d, got %0d", want.restart_event, got.restart_event);
          fail_count++;
        end
        if (got.restart_count !== want.restart_count) begin
          $error("restart_count: expected %0d, got %0d", want.restart_count, got.restart_count);
          fail_count++;
        end
      end
    end
  end

  // Abandon the run when no transfer happens on either side for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_arm_and_wrap();
    test_backpressure();
    test_fault_saturation();
    test_restart_saturation();
    test_random_configs();
    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
